// File: src/iprt_pkg.sv
// ----------------------------------------------------------------------------
// iprt_pkg
// Shared types and constants of the ipv4 pool range table.
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int MAX_POOLS     = 16;
  localparam int IDX_W         = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int CNT_W         = $clog2(MAX_POOLS + 1);
  localparam int ADDR_W        = 32;
  localparam int PLEN_W        = 6;
  localparam int POOL_INDEX_W  = 4;
  localparam int STATUS_W      = 2;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int IN_DATA_W     = 2 * ADDR_W;
  localparam int OUT_DATA_W    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SELECT = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OUTSIDE  = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NO_POOLS = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_PREFIX = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch a new transaction
    logic scan;    // walk the table one entry per cycle
    logic finish;  // form the result and commit an add
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic addr_in_subnet;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: src/iprt_ram.sv
// ----------------------------------------------------------------------------
// iprt_ram
// Generic single-clock ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module iprt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/iprt_ctrl.sv
// ----------------------------------------------------------------------------
// iprt_ctrl
// Sequencer of the pool table: takes a transaction, runs the scan when the op
// needs one, hands the result over to the output register.
// ----------------------------------------------------------------------------
module iprt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  iprt_pkg::sts_t sts_i,
  output iprt_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // only select and check look at the pools
        if ((sts_i.op == iprt_pkg::OP_SELECT && !sts_i.empty) ||
            (sts_i.op == iprt_pkg::OP_CHECK && !sts_i.empty && sts_i.addr_in_subnet)) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/iprt_datapath.sv
// ----------------------------------------------------------------------------
// iprt_datapath
// Subnet registers, pool storage, pool counter, range compare and the
// result register.
// ----------------------------------------------------------------------------
module iprt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iprt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [iprt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  iprt_pkg::op_e                       op_i,
  input  logic [iprt_pkg::ADDR_W-1:0]         addr_i,
  input  logic [iprt_pkg::ADDR_W-1:0]         pool_last_i,
  input  iprt_pkg::cmd_t                      cmd_i,
  output iprt_pkg::sts_t                      sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output iprt_pkg::status_e                   status_o,
  output logic [iprt_pkg::POOL_INDEX_W-1:0]   pool_index_o,
  output logic                                hit_o
);

  localparam int AW = iprt_pkg::ADDR_W;
  localparam int IW = iprt_pkg::IDX_W;
  localparam int CW = iprt_pkg::CNT_W;

  // configuration
  logic [AW-1:0]               subnet_q;
  logic [iprt_pkg::PLEN_W-1:0] plen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subnet_q <= '0;
      plen_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iprt_pkg::REG_SUBNET_PREFIX: subnet_q <= cfg_data_i[AW-1:0];
        iprt_pkg::REG_PREFIX_LENGTH: plen_q   <= cfg_data_i[iprt_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // a shift of 32 or more leaves an all-ones mask, same as a /32
  logic [AW-1:0] net_mask;
  logic [AW-1:0] net_base;
  assign net_mask = ~({AW{1'b1}} >> plen_q);
  assign net_base = subnet_q & net_mask;

  // latched transaction
  iprt_pkg::op_e op_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      addr_q <= addr_i;
      last_q <= pool_last_i;
    end
  end

  logic addr_in_sub;
  logic last_in_sub;
  assign addr_in_sub = (addr_q & net_mask) == net_base;
  assign last_in_sub = (last_q & net_mask) == net_base;

  // pool table
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   scan_q, scan_d;
  logic            rvld_q, rvld_d;
  logic [IW-1:0]   ridx_q;
  logic            found_q, found_d;
  logic [IW-1:0]   fidx_q;
  logic            rd_en;
  logic            wr_en;
  logic [2*AW-1:0] rdata;
  logic [AW-1:0]   rd_first;
  logic [AW-1:0]   rd_last;
  logic            match_now;
  logic            table_full;
  logic            add_ok;

  assign rd_first   = rdata[AW-1:0];
  assign rd_last    = rdata[2*AW-1:AW];
  assign match_now  = rvld_q && (rd_first <= addr_q) && (addr_q <= rd_last);
  assign table_full = cnt_q == CW'(iprt_pkg::MAX_POOLS);
  assign add_ok     = addr_in_sub && last_in_sub && !table_full;

  // one read issued per cycle, compare works on the registered read data
  assign rd_en = cmd_i.scan && !found_q && !match_now && (scan_q < cnt_q);
  assign wr_en = cmd_i.finish && (op_q == iprt_pkg::OP_ADD) && add_ok;

  iprt_ram #(
    .WIDTH (2 * AW),
    .DEPTH (iprt_pkg::MAX_POOLS)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i ({last_q, addr_q}),
    .re_i    (rd_en),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    cnt_d   = cnt_q;
    scan_d  = scan_q;
    rvld_d  = 1'b0;
    found_d = found_q;
    if (cmd_i.load) begin
      scan_d  = '0;
      found_d = 1'b0;
    end else begin
      if (rd_en) begin
        scan_d = scan_q + CW'(1);
        rvld_d = 1'b1;
      end
      if (cmd_i.scan && match_now && !found_q) begin
        found_d = 1'b1;
      end
    end
    if (wr_en) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      scan_q  <= '0;
      rvld_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      rvld_q  <= rvld_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ridx_q <= scan_q[IW-1:0];
    end
    if (cmd_i.scan && match_now && !found_q) begin
      fidx_q <= ridx_q;
    end
  end

  // result
  iprt_pkg::status_e                 res_status;
  logic [iprt_pkg::POOL_INDEX_W-1:0] res_index;
  logic                              res_hit;

  always_comb begin
    res_status = iprt_pkg::STATUS_OK;
    res_index  = '0;
    res_hit    = 1'b0;
    case (op_q)
      iprt_pkg::OP_ADD: begin
        if (!(addr_in_sub && last_in_sub)) begin
          res_status = iprt_pkg::STATUS_OUTSIDE;
        end else if (table_full) begin
          res_status = iprt_pkg::STATUS_FULL;
        end else begin
          res_index = iprt_pkg::POOL_INDEX_W'(cnt_q);
        end
      end
      iprt_pkg::OP_SELECT: begin
        if (cnt_q == '0) begin
          res_status = iprt_pkg::STATUS_NO_POOLS;
        end else if (found_q) begin
          res_index = iprt_pkg::POOL_INDEX_W'(fidx_q);
          res_hit   = 1'b1;
        end
      end
      iprt_pkg::OP_CHECK: begin
        res_hit = addr_in_sub && found_q;
      end
      default: ;
    endcase
  end

  logic                              out_valid_q;
  iprt_pkg::status_e                 out_status_q;
  logic [iprt_pkg::POOL_INDEX_W-1:0] out_index_q;
  logic                              out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_q <= res_status;
      out_index_q  <= res_index;
      out_hit_q    <= res_hit;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign pool_index_o = out_index_q;
  assign hit_o        = out_hit_q;

  assign sts_o.op             = op_q;
  assign sts_o.empty          = cnt_q == '0;
  assign sts_o.addr_in_subnet = addr_in_sub;
  assign sts_o.scan_done      = found_q || (!rvld_q && (scan_q >= cnt_q));
  assign sts_o.out_free       = !out_valid_q || out_ready_i;

endmodule

// File: src/ipv4_pool_range_table_top.sv
// ----------------------------------------------------------------------------
// ipv4_pool_range_table_top
// Table of ipv4 address pools inside one configurable subnet.
// ----------------------------------------------------------------------------
// One transaction at a time. An add or an unused op passes from acceptance
// through the exec and done states into the result register, and so does a
// select or check on an empty table or a check of an address outside the
// subnet. A select or check that walks the table goes through the scan
// state in between and reads the pool ram once per cycle through its single
// read port, with the compare in the cycle after the read; the scan stops
// after the last stored pool, or earlier when a pool matches. The done state
// loads the result only once the output register is free. The next
// transaction is accepted in the cycle after the result is loaded, even while
// that result still waits on the output side. Configuration writes take effect
// on the next edge and belong to idle periods only.
module ipv4_pool_range_table_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [iprt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [iprt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // addr [31:0], pool_last [63:32]
  input  logic [iprt_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // op [1:0]
  input  logic [iprt_pkg::OP_W-1:0]           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status [1:0], pool_index [5:2], hit [6], zero [7]
  output logic [iprt_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  iprt_pkg::cmd_t                    cmd;
  iprt_pkg::sts_t                    sts;
  iprt_pkg::status_e                 status;
  logic [iprt_pkg::POOL_INDEX_W-1:0] pool_index;
  logic                              hit;

  iprt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iprt_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (iprt_pkg::op_e'(s_axis_tuser_i)),
    .addr_i       (s_axis_tdata_i[iprt_pkg::ADDR_W-1:0]),
    .pool_last_i  (s_axis_tdata_i[2*iprt_pkg::ADDR_W-1:iprt_pkg::ADDR_W]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (status),
    .pool_index_o (pool_index),
    .hit_o        (hit)
  );

  assign m_axis_tdata_o = {1'b0, hit, pool_index, status};

endmodule

// File: tb/tb_ipv4_pool_range_table_top.sv
// ----------------------------------------------------------------------------
// tb_ipv4_pool_range_table_top
// Drives adds, selects, checks and unused ops through the pool table under several subnet
// settings and handshake idling modes. Every result is compared field by field
// against an in-bench copy of the pool table.
// ----------------------------------------------------------------------------
module tb_ipv4_pool_range_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int          MAX_PRINTS  = 50;
  localparam int          EXP_DEPTH   = 2048;

  typedef struct packed {
    iprt_pkg::status_e status;
    logic [3:0]        index;
    logic              hit;
  } pool_reply_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               cfg_we_i = 1'b0;
  logic [iprt_pkg::CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [iprt_pkg::CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                               s_axis_tvalid_i = 1'b0;
  logic                               s_axis_tready_o;
  logic [iprt_pkg::IN_DATA_W-1:0]     s_axis_tdata_i = '0;  // addr [31:0], pool_last [63:32]
  logic [iprt_pkg::OP_W-1:0]          s_axis_tuser_i = '0;  // op [1:0]
  logic                               m_axis_tvalid_o;
  logic                               m_axis_tready_i = 1'b0;
  logic [iprt_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o;  // status [1:0], pool_index [5:2], hit [6]

  // shadow of the block state
  logic [31:0]  cfg_subnet = '0;
  logic [5:0]   cfg_plen = '0;
  logic [31:0]  pool_lo [iprt_pkg::MAX_POOLS];
  logic [31:0]  pool_hi [iprt_pkg::MAX_POOLS];
  int           pool_cnt = 0;

  // expected results, written on input acceptance, read on output acceptance
  pool_reply_t  exp_mem [EXP_DEPTH];
  int           exp_wr = 0;
  int           exp_rd = 0;
  int           err_count = 0;
  int unsigned  cycle_count = 0;
  int           sender_idle_pct = 0;
  int           sink_stall_pct = 0;

  ipv4_pool_range_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ipv4_pool_range_table_top test failed");
      $finish;
    end
  end

  function automatic logic [31:0] net_mask();
    int unsigned len;
    len = (cfg_plen > 6'd32) ? 32 : cfg_plen;
    return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
  endfunction

  function automatic bit in_subnet(logic [31:0] a);
    logic [31:0] m;
    logic [31:0] lo;
    m  = net_mask();
    lo = cfg_subnet & m;
    return (a >= lo) && (a <= (lo | ~m));
  endfunction

  // applies one transaction to the shadow table and returns its result
  function automatic pool_reply_t apply_pool_op(iprt_pkg::op_e op, logic [31:0] a,
                                                logic [31:0] b);
    pool_reply_t r;
    r.status = iprt_pkg::STATUS_OK;
    r.index  = '0;
    r.hit    = 1'b0;
    case (op)
      iprt_pkg::OP_ADD: begin
        if (!in_subnet(a) || !in_subnet(b)) begin
          r.status = iprt_pkg::STATUS_OUTSIDE;
        end else if (pool_cnt >= iprt_pkg::MAX_POOLS) begin
          r.status = iprt_pkg::STATUS_FULL;
        end else begin
          pool_lo[pool_cnt] = a;
          pool_hi[pool_cnt] = b;
          r.index = 4'(pool_cnt);
          pool_cnt++;
        end
      end
      iprt_pkg::OP_SELECT: begin
        if (pool_cnt == 0) begin
          r.status = iprt_pkg::STATUS_NO_POOLS;
        end else begin
          for (int i = 0; i < pool_cnt; i++) begin
            if (!r.hit && pool_lo[i] <= a && a <= pool_hi[i]) begin
              r.index = 4'(i);
              r.hit   = 1'b1;
            end
          end
        end
      end
      iprt_pkg::OP_CHECK: begin
        if (in_subnet(a)) begin
          for (int i = 0; i < pool_cnt; i++) begin
            if (pool_lo[i] <= a && a <= pool_hi[i]) r.hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_reply(pool_reply_t r);
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endtask

  task automatic flag_mismatch(string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // result checker and output-side stall generator
  always @(posedge clk_i) begin
    pool_reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_rd == exp_wr) begin
        flag_mismatch($sformatf("result %h with nothing outstanding", m_axis_tdata_o));
      end else begin
        want = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (m_axis_tdata_o[1:0] !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", m_axis_tdata_o[1:0], want.status));
        if (m_axis_tdata_o[5:2] !== want.index)
          flag_mismatch($sformatf("pool_index %0d, want %0d", m_axis_tdata_o[5:2],
                                  want.index));
        if (m_axis_tdata_o[6] !== want.hit)
          flag_mismatch($sformatf("hit %b, want %b", m_axis_tdata_o[6], want.hit));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // valid stays high between back-to-back transactions, lowered only on a gap
  task automatic send_pool_op(iprt_pkg::op_e op, logic [31:0] a, logic [31:0] b);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    queue_reply(apply_pool_op(op, a, b));
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [iprt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == iprt_pkg::REG_SUBNET_PREFIX) cfg_subnet = data;
    else cfg_plen = data[5:0];
  endtask

  // reset config covers the whole address space, table still empty
  task automatic test_empty_table();
    send_pool_op(iprt_pkg::OP_SELECT, 32'h0000_0000, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_CHECK,  32'hFFFF_FFFF, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pool_op(iprt_pkg::OP_SELECT, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_add_rules();
    wait_idle();
    write_reg(iprt_pkg::REG_SUBNET_PREFIX, 32'h0A12_3456);  // host bits set on purpose
    write_reg(iprt_pkg::REG_PREFIX_LENGTH, 32'd8);
    send_pool_op(iprt_pkg::OP_ADD, 32'h09FF_FFFF, 32'h0A00_0010);  // first end outside
    send_pool_op(iprt_pkg::OP_ADD, 32'h0A00_0000, 32'h0B00_0000);  // last end outside
    send_pool_op(iprt_pkg::OP_ADD, 32'h0A00_0100, 32'h0A00_01FF);
    send_pool_op(iprt_pkg::OP_ADD, 32'h0A00_0300, 32'h0A00_0280);  // reversed, holds nothing
    send_pool_op(iprt_pkg::OP_ADD, 32'h0A00_0180, 32'h0A00_0400);  // overlaps pool 0
    send_pool_op(iprt_pkg::OP_NONE, 32'h0A00_0100, 32'h0A00_01FF);
  endtask

  task automatic test_select_and_check();
    send_pool_op(iprt_pkg::OP_SELECT, 32'h0A00_0180, 32'hFFFF_FFFF);  // first of two matches
    send_pool_op(iprt_pkg::OP_SELECT, 32'h0A00_0300, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_SELECT, 32'h0A00_0500, 32'h0000_0000);  // no match
    send_pool_op(iprt_pkg::OP_CHECK,  32'h0A00_01FF, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_CHECK,  32'h0A00_0401, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_CHECK,  32'h0A00_02C0, 32'h0000_0000);
  endtask

  task automatic test_prefix_extremes();
    wait_idle();
    write_reg(iprt_pkg::REG_SUBNET_PREFIX, 32'hC0A8_0101);
    write_reg(iprt_pkg::REG_PREFIX_LENGTH, 32'd63);  // clamps to a single address
    send_pool_op(iprt_pkg::OP_ADD,    32'hC0A8_0101, 32'hC0A8_0102);
    send_pool_op(iprt_pkg::OP_ADD,    32'hC0A8_0101, 32'hC0A8_0101);
    send_pool_op(iprt_pkg::OP_SELECT, 32'h0A00_0100, 32'h0000_0000);  // select ignores subnet
    send_pool_op(iprt_pkg::OP_CHECK,  32'h0A00_0100, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_CHECK,  32'hC0A8_0101, 32'h0000_0000);
    wait_idle();
    write_reg(iprt_pkg::REG_SUBNET_PREFIX, 32'hFFFF_FFFF);
    write_reg(iprt_pkg::REG_PREFIX_LENGTH, 32'd0);
    send_pool_op(iprt_pkg::OP_ADD,    32'h0000_0000, 32'h0000_0010);
    send_pool_op(iprt_pkg::OP_ADD,    32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_pool_op(iprt_pkg::OP_CHECK,  32'h0000_0000, 32'h0000_0000);
    send_pool_op(iprt_pkg::OP_SELECT, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    int            plen_list [8] = '{0, 63, 8, 32, 16, 24, 1, 31};
    int            r;
    int            i;
    iprt_pkg::op_e op;
    logic [31:0]   a;
    logic [31:0]   b;
    logic [31:0]   m;
    logic [31:0]   base;
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 75; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 75; end
        default: begin sender_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      // half the time, once pools exist, put the subnet on a stored pool's first address so checks can hit
      if (pool_cnt > 0 && $urandom_range(1) == 1)
        write_reg(iprt_pkg::REG_SUBNET_PREFIX, pool_lo[$urandom_range(pool_cnt - 1)]);
      else
        write_reg(iprt_pkg::REG_SUBNET_PREFIX, $urandom);
      write_reg(iprt_pkg::REG_PREFIX_LENGTH, 32'(plen_list[ph]));
      m    = net_mask();
      base = cfg_subnet & m;
      for (int k = 0; k < 130; k++) begin
        if (k == 65) wait_idle();
        r = $urandom_range(99);
        a = $urandom;
        b = $urandom;
        if (r < 12) begin
          op = iprt_pkg::OP_ADD;
          if ($urandom_range(9) < 8) begin
            a = base | (a & ~m);
            if ($urandom_range(9) == 0) b = a - 32'($urandom_range(1, 64));
            else b = a + 32'($urandom_range(0, 300));
            b = base | (b & ~m);
          end
        end else if (r < 95) begin
          op = (r < 52) ? iprt_pkg::OP_SELECT : iprt_pkg::OP_CHECK;
          case ($urandom_range(3))
            0, 1: begin
              if (pool_cnt > 0) begin
                i = $urandom_range(pool_cnt - 1);
                case ($urandom_range(4))
                  0: a = pool_lo[i] - 32'd1;
                  1: a = pool_lo[i];
                  2: a = pool_hi[i];
                  3: a = pool_hi[i] + 32'd1;
                  default: begin
                    if (pool_lo[i] <= pool_hi[i])
                      a = pool_lo[i] + $urandom_range(pool_hi[i] - pool_lo[i]);
                    else
                      a = pool_lo[i];
                  end
                endcase
              end
            end
            2: a = base | (a & ~m);
            default: ;
          endcase
        end else begin
          op = iprt_pkg::OP_NONE;
        end
        send_pool_op(op, a, b);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_add_rules();
    test_select_and_check();
    test_prefix_extremes();
    test_random_traffic();
    wait_idle();
    repeat (30) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ipv4_pool_range_table_top test passed");
    end else begin
      $display("ipv4_pool_range_table_top test failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/iprt_pkg.sv
src/iprt_ram.sv
src/iprt_ctrl.sv
src/iprt_datapath.sv
src/ipv4_pool_range_table_top.sv
tb/tb_ipv4_pool_range_table_top.sv
